FILE: hw/rtl/seah_pkg.sv
// shared constants, types and state codes for the streaming seahash block
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package seah_pkg;

    // diffusion multiplier, split into halves for the partial products
    localparam logic [63:0] SEAH_MUL    = 64'h6eed0e9da4d94a4f;
    localparam logic [31:0] SEAH_MUL_LO = SEAH_MUL[31:0];
    localparam logic [31:0] SEAH_MUL_HI = SEAH_MUL[63:32];

    // lane start values, oldest lane first
    localparam int unsigned SEAH_LANES = 4;
    localparam logic [63:0] SEAH_INIT [SEAH_LANES] = '{
        64'h16f11fe89b0d677c,
        64'hb480a793d8e6c86c,
        64'h6fe2e5aaf078ebc9,
        64'h14f994a4c5259381
    };

    // full count of bytes in one word
    localparam logic [3:0] SEAH_FULL_COUNT = 4'd8;

    // default depth of the queue between front and back
    localparam int unsigned SEAH_QUEUE_DEPTH = 4;

    // classified item as held in the queue
    typedef struct packed {
        logic [63:0] word;
        logic [3:0]  cnt;
        logic        absorb;
        logic        last;
    } t_item;

    // tag that travels with an operand through the diffuser
    typedef struct packed {
        logic       dig;
        logic [1:0] slot;
    } t_tag;

    // back end sequencing
    typedef enum logic {
        BS_RUN,
        BS_DRAIN
    } t_bstate;

endpackage

FILE: hw/rtl/seah_front.sv
// front end: takes input items, saturates the count, masks unused bytes, classifies
// depends on seah_pkg; feeds seah_queue
`timescale 1ns / 1ps

module seah_front (
    input  logic            i_valid,
    input  logic [63:0]     i_word,
    input  logic [3:0]      i_byte_count,
    input  logic            i_last,
    input  logic            i_q_full,
    output logic            o_stall,
    output logic            o_push,
    output seah_pkg::t_item o_item
);
    import seah_pkg::*;

    logic [3:0]  w_cnt;
    logic [63:0] w_mask;

    // counts above a full word count as a full word
    assign w_cnt = (i_byte_count > SEAH_FULL_COUNT) ? SEAH_FULL_COUNT : i_byte_count;

    // keep byte lanes below the count
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            w_mask[i*8 +: 8] = (4'(i) < w_cnt) ? 8'hff : 8'h00;
        end
    end

    // accept whenever the queue has room
    assign o_stall = i_q_full;
    assign o_push  = i_valid && !i_q_full;

    assign o_item.word   = i_word & w_mask;
    assign o_item.cnt    = w_cnt;
    assign o_item.absorb = (w_cnt != 4'd0);
    assign o_item.last   = i_last;

endmodule

FILE: hw/rtl/seah_queue.sv
// short queue of classified items between front and back
// depends on seah_pkg
`timescale 1ns / 1ps

module seah_queue #(
    parameter int unsigned DEPTH = seah_pkg::SEAH_QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  seah_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output seah_pkg::t_item o_item
);
    import seah_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_item         r_mem [DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          w_push, w_pop;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    // pointer and fill count update
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (w_push) begin
            n_wr = (r_wr == LAST_IDX) ? '0 : r_wr + PW'(1);
        end
        if (w_pop) begin
            n_rd = (r_rd == LAST_IDX) ? '0 : r_rd + PW'(1);
        end
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // item storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

FILE: hw/rtl/seah_mix.sv
// diffuser stages: multiply, shift xor, multiply, fixed latency, no stall
// depends on seah_pkg; shared by lane updates and the final digest
`timescale 1ns / 1ps

module seah_mix (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [63:0]    i_x,
    input  seah_pkg::t_tag i_tag,
    output logic           o_valid,
    output logic [63:0]    o_res,
    output seah_pkg::t_tag o_tag,
    output logic           o_busy
);
    import seah_pkg::*;

    logic        r1_valid, r2_valid, r3_valid;
    t_tag        r1_tag, r2_tag, r3_tag;
    logic [63:0] r1_ll, r3_ll;
    logic [31:0] r1_lh, r1_hl, r3_lh, r3_hl;
    logic [63:0] r2_z;
    logic [63:0] w_y, w_z;

    // first multiply: low 64 bits from three 32x32 partial products
    always_ff @(posedge i_clk) begin
        r1_ll  <= {32'd0, i_x[31:0]} * {32'd0, SEAH_MUL_LO};
        r1_lh  <= i_x[31:0] * SEAH_MUL_HI;
        r1_hl  <= i_x[63:32] * SEAH_MUL_LO;
        r1_tag <= i_tag;
    end

    // sum the partials, then the data-dependent shift xor
    assign w_y = r1_ll + {r1_lh + r1_hl, 32'd0};
    assign w_z = w_y ^ ((w_y >> 32) >> w_y[63:60]);

    always_ff @(posedge i_clk) begin
        r2_z   <= w_z;
        r2_tag <= r1_tag;
    end

    // second multiply partials
    always_ff @(posedge i_clk) begin
        r3_ll  <= {32'd0, r2_z[31:0]} * {32'd0, SEAH_MUL_LO};
        r3_lh  <= r2_z[31:0] * SEAH_MUL_HI;
        r3_hl  <= r2_z[63:32] * SEAH_MUL_LO;
        r3_tag <= r2_tag;
    end

    // final sum
    assign o_res   = r3_ll + {r3_lh + r3_hl, 32'd0};
    assign o_tag   = r3_tag;
    assign o_valid = r3_valid;
    assign o_busy  = r1_valid || r2_valid || r3_valid;

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

endmodule

FILE: hw/rtl/seah_back.sv
// back end: lane ring, byte total, issue to the diffuser, digest output register
// depends on seah_pkg; drives seah_mix and pops seah_queue
`timescale 1ns / 1ps

module seah_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  seah_pkg::t_item i_q_item,
    output logic            o_q_pop,
    output logic            o_mix_valid,
    output logic [63:0]     o_mix_x,
    output seah_pkg::t_tag  o_mix_tag,
    input  logic            i_mix_valid,
    input  logic [63:0]     i_mix_res,
    input  seah_pkg::t_tag  i_mix_tag,
    input  logic            i_mix_busy,
    output logic            o_valid,
    output logic [63:0]     o_digest,
    input  logic            i_stall
);
    import seah_pkg::*;

    t_bstate     r_state, n_state;
    logic [63:0] r_lane [SEAH_LANES];
    logic [1:0]  r_ptr;
    logic [63:0] r_total;
    logic        r_out_valid;
    logic [63:0] r_digest;
    logic        w_absorb, w_finish;
    logic [63:0] w_fold;

    // the lane ring rotates by pointer: the oldest lane is the one at r_ptr
    assign w_fold = r_lane[0] ^ r_lane[1] ^ r_lane[2] ^ r_lane[3] ^ r_total;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BS_RUN: begin
                if (i_q_valid && i_q_item.last) begin
                    n_state = BS_DRAIN;
                end
            end
            BS_DRAIN: begin
                if (!i_mix_busy && !r_out_valid) begin
                    n_state = BS_RUN;
                end
            end
            default: n_state = BS_RUN;
        endcase
    end

    // state outputs
    always_comb begin
        o_q_pop  = 1'b0;
        w_absorb = 1'b0;
        w_finish = 1'b0;
        unique case (r_state)
            BS_RUN: begin
                o_q_pop  = i_q_valid;
                w_absorb = i_q_valid && i_q_item.absorb;
            end
            BS_DRAIN: begin
                w_finish = !i_mix_busy && !r_out_valid;
            end
            default: begin
                o_q_pop = 1'b0;
            end
        endcase
    end

    // diffuser issue: a lane update or the closing fold
    assign o_mix_valid   = w_absorb || w_finish;
    assign o_mix_x       = w_finish ? w_fold : (r_lane[r_ptr] ^ i_q_item.word);
    assign o_mix_tag.dig = w_finish;
    assign o_mix_tag.slot = r_ptr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BS_RUN;
        end else begin
            r_state <= n_state;
        end
    end

    // lanes, pointer and total; the fold restores start values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SEAH_LANES; i++) begin
                r_lane[i] <= SEAH_INIT[i];
            end
            r_ptr   <= '0;
            r_total <= '0;
        end else if (w_finish) begin
            for (int i = 0; i < SEAH_LANES; i++) begin
                r_lane[i] <= SEAH_INIT[i];
            end
            r_ptr   <= '0;
            r_total <= '0;
        end else begin
            if (i_mix_valid && !i_mix_tag.dig) begin
                r_lane[i_mix_tag.slot] <= i_mix_res;
            end
            if (w_absorb) begin
                r_ptr   <= r_ptr + 2'd1;
                r_total <= r_total + {60'd0, i_q_item.cnt};
            end
        end
    end

    // digest output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_mix_valid && i_mix_tag.dig) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_mix_valid && i_mix_tag.dig) begin
            r_digest <= i_mix_res;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_digest = r_digest;

endmodule

FILE: hw/rtl/seahash_64_stream_top.sv
// top level of the streaming 64-bit seahash block
// depends on seah_pkg, seah_front, seah_queue, seah_mix, seah_back
//
// input channel: i_valid / o_stall with i_word, i_byte_count, i_last; an item
// is taken at a clock edge with i_valid high and o_stall low. bytes at and above
// i_byte_count are zeroed, counts above eight count as eight, and a word with a
// zero count adds nothing. output channel: o_valid / i_stall with o_digest, one
// item per message, taken at an edge with o_valid high and i_stall low.
// throughput: one word per cycle outside the drain at the end of each message;
// the diffuser fits the distance of four words between a lane's update and its
// next use. the last word of a message drains the diffuser, then sends the fold
// through it, and the digest is caught in the output register. the next
// message's words are taken into the queue meanwhile, until it fills.
// a stalled receiver holds the digest in the output register; the next
// message's digest then waits, and once the queue fills o_stall rises.
// reset (synchronous, active low) empties queue and diffuser and restores the
// start lanes and a zero byte total.
`timescale 1ns / 1ps

module seahash_64_stream_top #(
    parameter int unsigned QUEUE_DEPTH = seah_pkg::SEAH_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [63:0] i_word,
    input  logic [3:0]  i_byte_count,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_digest
);
    import seah_pkg::*;

    logic        w_push, w_full, w_q_valid, w_pop;
    t_item       w_front_item, w_q_item;
    logic        w_mix_in_valid, w_mix_out_valid, w_mix_busy;
    logic [63:0] w_mix_x, w_mix_res;
    t_tag        w_mix_in_tag, w_mix_out_tag;

    seah_front u_front (
        .i_valid      (i_valid),
        .i_word       (i_word),
        .i_byte_count (i_byte_count),
        .i_last       (i_last),
        .i_q_full     (w_full),
        .o_stall      (o_stall),
        .o_push       (w_push),
        .o_item       (w_front_item)
    );

    seah_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_item  (w_q_item)
    );

    seah_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_mix_in_valid),
        .i_x     (w_mix_x),
        .i_tag   (w_mix_in_tag),
        .o_valid (w_mix_out_valid),
        .o_res   (w_mix_res),
        .o_tag   (w_mix_out_tag),
        .o_busy  (w_mix_busy)
    );

    seah_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_item    (w_q_item),
        .o_q_pop     (w_pop),
        .o_mix_valid (w_mix_in_valid),
        .o_mix_x     (w_mix_x),
        .o_mix_tag   (w_mix_in_tag),
        .i_mix_valid (w_mix_out_valid),
        .i_mix_res   (w_mix_res),
        .i_mix_tag   (w_mix_out_tag),
        .i_mix_busy  (w_mix_busy),
        .o_valid     (o_valid),
        .o_digest    (o_digest),
        .i_stall     (i_stall)
    );

endmodule

FILE: tb/tb_top.sv
// self-checking testbench for seahash_64_stream_top: random and directed messages
// depends on seahash_64_stream_top and the rtl it pulls in; the expected digests come
// from an in-bench seahash model
`timescale 1ns / 1ps

module tb_top;

    localparam logic [63:0] MIX_MUL = 64'h6eed0e9da4d94a4f;
    localparam logic [63:0] LANE_START [4] = '{
        64'h16f11fe89b0d677c,
        64'hb480a793d8e6c86c,
        64'h6fe2e5aaf078ebc9,
        64'h14f994a4c5259381
    };
    localparam int unsigned MSG_ITEMS  = 1350;
    localparam int unsigned QUIET_TAIL = 150;
    localparam int unsigned HOLD_AT    = 500;
    localparam int unsigned HOLD_LEN   = 400;

    typedef struct packed {
        logic [63:0] word;
        logic [3:0]  count;
        logic        last;
    } t_msg_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [63:0] i_word = '0;
    logic [3:0]  i_byte_count = '0;
    logic        i_last = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [63:0] o_digest;

    t_msg_word   word_backlog [$];
    logic [63:0] digest_due [$];
    logic [63:0] lane [4] = LANE_START;
    logic [63:0] byte_total = '0;
    logic        item_taken = 1'b0;
    int unsigned items_taken = 0;
    int unsigned mismatches = 0;

    seahash_64_stream_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_word       (i_word),
        .i_byte_count (i_byte_count),
        .i_last       (i_last),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_digest     (o_digest)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // seahash diffusion: multiply, data-dependent shift xor, multiply
    function automatic logic [63:0] seahash_mix(input logic [63:0] v);
        logic [63:0] x;
        x = v * MIX_MUL;
        x = x ^ ((x >> 32) >> x[63:60]);
        x = x * MIX_MUL;
        return x;
    endfunction

    // fold one accepted item into the lanes, queue the digest on last
    task automatic absorb_word(input logic [63:0] w, input logic [3:0] cnt_in,
                               input logic fin);
        logic [3:0]  cnt;
        logic [63:0] keep;
        logic [63:0] fresh;
        cnt = (cnt_in > 4'd8) ? 4'd8 : cnt_in;
        if (cnt != 4'd0) begin
            keep  = (cnt == 4'd8) ? '1 : ((64'd1 << {cnt, 3'b000}) - 64'd1);
            fresh = seahash_mix(lane[0] ^ (w & keep));
            lane[0] = lane[1];
            lane[1] = lane[2];
            lane[2] = lane[3];
            lane[3] = fresh;
            byte_total = byte_total + 64'(cnt);
        end
        if (fin) begin
            digest_due.push_back(seahash_mix(lane[0] ^ lane[1] ^ lane[2] ^ lane[3]
                                             ^ byte_total));
            lane = LANE_START;
            byte_total = '0;
        end
    endtask

    task automatic add_item(input logic [63:0] w, input logic [3:0] cnt, input logic fin);
        t_msg_word it;
        it.word  = w;
        it.count = cnt;
        it.last  = fin;
        word_backlog.push_back(it);
    endtask

    // input side: record each accepted item and predict its digest
    always @(posedge i_clk) begin
        item_taken <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n && i_valid && !o_stall) begin
            absorb_word(i_word, i_byte_count, i_last);
            items_taken <= items_taken + 1;
        end
    end

    // sender: next item after each acceptance, random gaps in stretches
    always @(negedge i_clk) begin : feed
        int unsigned gap_left;
        int unsigned stretch_left;
        int unsigned gap_pct;
        t_msg_word   cur;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            gap_left = 0;
            stretch_left = 0;
            gap_pct = 0;
        end else begin
            if (stretch_left == 0) begin
                stretch_left = $urandom_range(40, 160);
                case ($urandom_range(0, 2))
                    0: gap_pct = 0;
                    1: gap_pct = 10;
                    default: gap_pct = 30;
                endcase
            end
            stretch_left--;
            if (!i_valid || item_taken) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (word_backlog.size() == 0) begin
                    i_valid <= 1'b0;
                end else if (word_backlog.size() >= QUIET_TAIL
                             && $urandom_range(0, 99) < gap_pct) begin
                    gap_left = $urandom_range(0, 16);
                    i_valid <= 1'b0;
                end else begin
                    cur = word_backlog.pop_front();
                    i_valid      <= 1'b1;
                    i_word       <= cur.word;
                    i_byte_count <= cur.count;
                    i_last       <= cur.last;
                end
            end
        end
    end

    // receiver: random stall bursts plus one long hold to back the block up
    always @(negedge i_clk) begin : drain
        int unsigned stall_left;
        int unsigned hold_left;
        int unsigned stretch_left;
        int unsigned stall_pct;
        logic        hold_done;
        logic        nxt;
        if (!i_rst_n) begin
            stall_left = 0;
            hold_left = 0;
            stretch_left = 0;
            stall_pct = 0;
            hold_done = 1'b0;
            nxt = 1'b0;
        end else begin
            if (stretch_left == 0) begin
                stretch_left = $urandom_range(40, 160);
                case ($urandom_range(0, 2))
                    0: stall_pct = 0;
                    1: stall_pct = 8;
                    default: stall_pct = 25;
                endcase
            end
            stretch_left--;
            if (hold_left > 0) begin
                hold_left--;
                nxt = 1'b1;
            end else if (!hold_done && items_taken >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_LEN - 1;
                nxt = 1'b1;
            end else if (word_backlog.size() < QUIET_TAIL) begin
                stall_left = 0;
                nxt = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                nxt = 1'b1;
            end else if ($urandom_range(0, 99) < stall_pct) begin
                stall_left = $urandom_range(0, 16);
                nxt = 1'b1;
            end else begin
                nxt = 1'b0;
            end
        end
        i_stall <= nxt;
    end

    // output side: compare each digest with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (digest_due.size() == 0) begin
                $error("digest: expected none, actual %h", o_digest);
                mismatches++;
            end else begin
                if (o_digest !== digest_due[0]) begin
                    $error("digest: expected %h, actual %h", digest_due[0], o_digest);
                    mismatches++;
                end
                void'(digest_due.pop_front());
            end
        end
    end

    // stimulus, reset and end of run
    initial begin
        int unsigned fed;
        int unsigned nw;
        logic        noisy;
        logic        fin;
        logic [3:0]  cnt;
        logic [63:0] w;

        // empty message, masking and byte counts one to eight
        add_item({$urandom, $urandom}, 4'd0, 1'b1);
        add_item('1, 4'd0, 1'b1);
        add_item('1, 4'd8, 1'b1);
        add_item('0, 4'd8, 1'b1);
        for (int c = 1; c < 8; c++) add_item('1, 4'(c), 1'b1);
        // counts above eight saturate
        add_item('1, 4'd9, 1'b1);
        add_item('1, 4'd15, 1'b1);
        // zero-byte and short words in the middle of a message
        add_item(64'h0123456789abcdef, 4'd8, 1'b0);
        add_item('1, 4'd0, 1'b0);
        add_item({$urandom, $urandom}, 4'd3, 1'b0);
        add_item({$urandom, $urandom}, 4'd12, 1'b0);
        add_item({$urandom, $urandom}, 4'd8, 1'b0);
        add_item({$urandom, $urandom}, 4'd5, 1'b1);

        // mostly well-formed messages, some with random counts throughout
        fed = 0;
        while (fed < MSG_ITEMS) begin
            nw = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            noisy = ($urandom_range(0, 4) == 0);
            for (int k = 0; k < nw; k++) begin
                fin = (k == nw - 1);
                cnt = fin ? 4'($urandom_range(0, 8)) : 4'd8;
                if (noisy && $urandom_range(0, 2) == 0) cnt = 4'($urandom_range(0, 15));
                case ($urandom_range(0, 9))
                    0: w = '0;
                    1: w = '1;
                    default: w = {$urandom, $urandom};
                endcase
                add_item(w, cnt, fin);
                if (fin || cnt != 4'd0) fed++;
            end
        end

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (word_backlog.size() != 0 || i_valid) @(posedge i_clk);
        while (digest_due.size() != 0) @(posedge i_clk);
        repeat (24) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/seah_pkg.sv
hw/rtl/seah_front.sv
hw/rtl/seah_queue.sv
hw/rtl/seah_mix.sv
hw/rtl/seah_back.sv
hw/rtl/seahash_64_stream_top.sv
tb/tb_top.sv
